/* design/lpmd_pkg.sv */
// Package for the length-prefixed message deframer.
// Holds result kind codes, error codes, header constants and the result struct.
// No dependencies.
package lpmd_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_COMPRESSED = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG   = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

  // header is one flag byte plus a 32-bit big-endian length
  localparam int unsigned HdrBytes = 5;
  localparam logic [2:0]  HdrLastIdx = 3'(HdrBytes - 1);

  localparam logic [31:0] MaxSizeReset = 32'd4194304;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    logic       last_of_message;
    logic [1:0] err_code;
  } result_t;

endpackage

/* design/length_prefixed_message_deframer.sv */
// Top level of the length-prefixed message deframer.
// Depends on lpmd_pkg and lpmd_frame. Input register, decode, result register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  in      | in        | in_valid_i / in_stall_o   | op_i, data_byte_i
//  out     | out       | out_valid_o / out_stall_i | kind_o, payload_byte_o,
//          |           |                           | last_of_message_o, err_code_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_data_i (size limit)
//
// One item per cycle unless out_stall_i holds it; results leave via the result register.
// The input register keeps taking items while a result waits in the output register.
// An item with a result waits in the input register while the output register is held.
// Reset puts the framer at the start of a header and the size limit at 4194304.
module length_prefixed_message_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_of_message_o,
  output logic [1:0]  err_code_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic              in_vld_q, in_vld_d;
  logic              op_q;
  logic [7:0]        byte_q;
  logic [31:0]       max_size_q;
  logic              out_vld_q, out_vld_d;
  lpmd_pkg::result_t res, res_q;
  logic              has_result;
  logic              out_free;
  logic              advance;
  logic              in_acc;
  logic              out_load;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (!has_result || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = advance && has_result;
  assign in_vld_d   = in_acc || (in_vld_q && !advance);
  assign out_vld_d  = out_load || (out_vld_q && out_stall_i);
  assign cfg_ready_o = 1'b1;

  lpmd_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .op_i         (op_q),
    .byte_i       (byte_q),
    .max_size_i   (max_size_q),
    .has_result_o (has_result),
    .result_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      max_size_q <= lpmd_pkg::MaxSizeReset;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_size_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_i;
      byte_q <= data_byte_i;
    end
    if (out_load) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign kind_o            = res_q.kind;
  assign payload_byte_o    = res_q.payload_byte;
  assign last_of_message_o = res_q.last_of_message;
  assign err_code_o        = res_q.err_code;

endmodule

/* design/lpmd_frame.sv */
// Framing state and per-byte decode for the deframer.
// Depends on lpmd_pkg. Updates state on step_i and reports the result, if any,
// for the item presented this cycle.
module lpmd_frame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  op_i,
  input  logic [7:0]            byte_i,
  input  logic [31:0]           max_size_i,
  output logic                  has_result_o,
  output lpmd_pkg::result_t     result_o
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2,
    PH_ENDED   = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_idx_q, hdr_idx_d;
  logic        flag_q, flag_d;
  logic [31:0] len_q, len_d;
  logic [31:0] len_shift;

  assign len_shift = {len_q[23:0], byte_i};

  always_comb begin
    phase_d      = phase_q;
    hdr_idx_d    = hdr_idx_q;
    flag_d       = flag_q;
    len_d        = len_q;
    has_result_o = 1'b0;
    result_o     = '{kind: lpmd_pkg::KIND_BYTE, payload_byte: 8'd0,
                     last_of_message: 1'b0, err_code: lpmd_pkg::ERR_NONE};
    case (phase_q)
      PH_ERROR: begin
      end
      PH_ENDED: begin
        if (op_i) begin
          has_result_o  = 1'b1;
          result_o.kind = lpmd_pkg::KIND_END;
        end
      end
      default: begin
        if (op_i) begin
          has_result_o = 1'b1;
          if (phase_q == PH_HEADER && hdr_idx_q == 3'd0) begin
            phase_d       = PH_ENDED;
            result_o.kind = lpmd_pkg::KIND_END;
          end else begin
            phase_d           = PH_ERROR;
            result_o.kind     = lpmd_pkg::KIND_ERROR;
            result_o.err_code = lpmd_pkg::ERR_TRUNCATED;
          end
        end else if (phase_q == PH_PAYLOAD) begin
          has_result_o             = 1'b1;
          len_d                    = len_q - 32'd1;
          result_o.payload_byte    = byte_i;
          result_o.last_of_message = (len_q == 32'd1);
          if (len_q == 32'd1) begin
            phase_d   = PH_HEADER;
            hdr_idx_d = 3'd0;
          end
        end else if (hdr_idx_q == 3'd0) begin
          flag_d    = (byte_i != 8'd0);
          len_d     = 32'd0;
          hdr_idx_d = 3'd1;
        end else begin
          len_d     = len_shift;
          hdr_idx_d = hdr_idx_q + 3'd1;
          if (hdr_idx_q == lpmd_pkg::HdrLastIdx) begin
            hdr_idx_d = 3'd0;
            if (flag_q) begin
              has_result_o      = 1'b1;
              phase_d           = PH_ERROR;
              result_o.kind     = lpmd_pkg::KIND_ERROR;
              result_o.err_code = lpmd_pkg::ERR_COMPRESSED;
            end else if (len_shift > max_size_i) begin
              has_result_o      = 1'b1;
              phase_d           = PH_ERROR;
              result_o.kind     = lpmd_pkg::KIND_ERROR;
              result_o.err_code = lpmd_pkg::ERR_TOO_LONG;
            end else if (len_shift == 32'd0) begin
              has_result_o  = 1'b1;
              result_o.kind = lpmd_pkg::KIND_EMPTY;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_idx_q <= 3'd0;
      flag_q    <= 1'b0;
      len_q     <= 32'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      flag_q    <= flag_d;
      len_q     <= len_d;
    end
  end

endmodule

/* design/lpmd_checker.sv */
// Port-level checks for the deframer, bound to the top level.
// Depends on lpmd_pkg; sees only the top-level ports.
module lpmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  payload_byte_o,
  input logic        last_of_message_o,
  input logic [1:0]  err_code_o
);

  logic err_seen_q;

  // error is sticky: once an error transaction leaves, nothing follows it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && kind_o == lpmd_pkg::KIND_ERROR) begin
      err_seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(kind_o) && $stable(payload_byte_o)
      && $stable(last_of_message_o) && $stable(err_code_o))
    else $error("stalled result changed");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != lpmd_pkg::KIND_ERROR |-> err_code_o == lpmd_pkg::ERR_NONE)
    else $error("error code on non-error result");

  a_no_byte_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != lpmd_pkg::KIND_BYTE |-> payload_byte_o == 8'd0
      && !last_of_message_o)
    else $error("payload fields on non-byte result");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_seen_q |-> !out_valid_o)
    else $error("result after error");

endmodule

bind length_prefixed_message_deframer lpmd_checker u_lpmd_checker (.*);

/* verif/tb_top.sv */
// Testbench for length_prefixed_message_deframer: random framed body streams, random stalls.
// A scoreboard class predicts the deframer output per accepted body item and checks results.
// Depends on lpmd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb_top;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_PAYLOAD,
    ST_FAILED,
    ST_ENDED
  } stream_state_e;

  typedef enum int {
    FIN_TOO_LONG,
    FIN_COMPRESSED,
    FIN_CUT_HEADER,
    FIN_CUT_PAYLOAD,
    FIN_CLEAN_END
  } finish_case_e;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;
  localparam int   RandItems = 1650;

  // Tracks deframer state and the results still owed by the block.
  class deframe_scoreboard;
    stream_state_e      state;
    logic [2:0]         hdr_count;
    logic               flag_set;
    logic [31:0]        length_left;
    logic [31:0]        size_limit;
    lpmd_pkg::result_t  owed_q[$];
    int                 mismatches;

    function new();
      state       = ST_HEADER;
      hdr_count   = '0;
      flag_set    = 1'b0;
      length_left = '0;
      size_limit  = lpmd_pkg::MaxSizeReset;
      mismatches  = 0;
    endfunction

    function void set_limit(logic [31:0] value);
      size_limit = value;
    endfunction

    function void owe(lpmd_pkg::kind_e kind, logic [7:0] data, logic last, logic [1:0] err);
      lpmd_pkg::result_t r;
      r.kind            = kind;
      r.payload_byte    = data;
      r.last_of_message = last;
      r.err_code        = err;
      owed_q = {owed_q, r};
    endfunction

    function void fail_stream(logic [1:0] err);
      state = ST_FAILED;
      owe(lpmd_pkg::KIND_ERROR, 8'h00, 1'b0, err);
    endfunction

    function void note_item(logic op, logic [7:0] data);
      logic last;
      case (state)
        ST_FAILED: ;
        ST_ENDED: begin
          if (op == OP_END) owe(lpmd_pkg::KIND_END, 8'h00, 1'b0, lpmd_pkg::ERR_NONE);
        end
        default: begin
          if (op == OP_END) begin
            if (state == ST_HEADER && hdr_count == 0) begin
              state = ST_ENDED;
              owe(lpmd_pkg::KIND_END, 8'h00, 1'b0, lpmd_pkg::ERR_NONE);
            end else begin
              fail_stream(lpmd_pkg::ERR_TRUNCATED);
            end
          end else if (state == ST_PAYLOAD) begin
            length_left = length_left - 32'd1;
            last = (length_left == 0);
            if (last) begin
              state     = ST_HEADER;
              hdr_count = '0;
            end
            owe(lpmd_pkg::KIND_BYTE, data, last, lpmd_pkg::ERR_NONE);
          end else if (hdr_count == 0) begin
            flag_set    = (data != 8'h00);
            length_left = '0;
            hdr_count   = 3'd1;
          end else begin
            length_left = {length_left[23:0], data};
            hdr_count   = hdr_count + 3'd1;
            if (hdr_count == 3'(lpmd_pkg::HdrBytes)) begin
              hdr_count = '0;
              // the flag is only acted on once the whole header is in
              if (flag_set) fail_stream(lpmd_pkg::ERR_COMPRESSED);
              else if (length_left > size_limit) fail_stream(lpmd_pkg::ERR_TOO_LONG);
              else if (length_left == 0)
                owe(lpmd_pkg::KIND_EMPTY, 8'h00, 1'b0, lpmd_pkg::ERR_NONE);
              else state = ST_PAYLOAD;
            end
          end
        end
      endcase
    endfunction

    function void report(string field, logic [7:0] exp, logic [7:0] got);
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, exp, got);
      mismatches++;
    endfunction

    function void check_result(lpmd_pkg::result_t got);
      lpmd_pkg::result_t exp;
      if (owed_q.size() == 0) begin
        $display("%0t ns: unexpected result, actual kind %0d byte %0h last %0b err %0d",
                 $time, got.kind, got.payload_byte, got.last_of_message, got.err_code);
        mismatches++;
        return;
      end
      exp = owed_q.pop_front();
      if (got.kind !== exp.kind) report("kind", 8'(exp.kind), 8'(got.kind));
      if (got.payload_byte !== exp.payload_byte)
        report("payload_byte", exp.payload_byte, got.payload_byte);
      if (got.last_of_message !== exp.last_of_message)
        report("last_of_message", 8'(exp.last_of_message), 8'(got.last_of_message));
      if (got.err_code !== exp.err_code)
        report("err_code", 8'(exp.err_code), 8'(got.err_code));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = OP_DATA;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic        last_of_message_o;
  logic [1:0]  err_code_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = 32'h0;

  deframe_scoreboard sb = new();
  logic [31:0] cur_limit = lpmd_pkg::MaxSizeReset;
  int          items_sent = 0;
  bit          quiet = 1'b0;
  bit          hold_off_req = 1'b0;

  length_prefixed_message_deframer i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .payload_byte_o    (payload_byte_o),
    .last_of_message_o (last_of_message_o),
    .err_code_o        (err_code_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // transaction monitor: sees pre-edge values, same as the block
  always @(posedge clk_i) begin
    lpmd_pkg::result_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_limit(cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_item(op_i, data_byte_i);
      if (out_valid_o && !out_stall_i) begin
        got.kind            = lpmd_pkg::kind_e'(kind_o);
        got.payload_byte    = payload_byte_o;
        got.last_of_message = last_of_message_o;
        got.err_code        = err_code_o;
        sb.check_result(got);
      end
    end
  end

  // result receiver
  initial begin
    int n;
    bit held_off;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req && !held_off) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        held_off = 1'b1;
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
      n = pick_gap();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  task automatic offer_body_item(input logic op, input logic [7:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= data;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_header(input logic [7:0] flag, input logic [31:0] len);
    offer_body_item(OP_DATA, flag);
    for (int i = 3; i >= 0; i--) offer_body_item(OP_DATA, len[8*i +: 8]);
  endtask

  task automatic send_payload(input int count);
    for (int i = 0; i < count; i++) offer_body_item(OP_DATA, 8'($urandom));
  endtask

  // lets in-flight items with no result clear before touching the register
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_size_limit(input logic [31:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_limit = value;
  endtask

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return 32'hFFFF_FFFF;
      1: return 32'd1;
      2: return $urandom_range(2, 64);
      3: return lpmd_pkg::MaxSizeReset;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    int r;
    logic [31:0] len;
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(0, 8);
    else if (r < 95) len = $urandom_range(9, 40);
    else len = $urandom_range(41, 200);
    if (len > cur_limit) len = cur_limit;
    return len;
  endfunction

  initial begin
    logic [31:0]  len;
    int           phase_end;
    int           phase_no;
    finish_case_e fin;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, byte extremes, length at the limit, limit of zero
    send_header(8'h00, 32'd0);
    send_header(8'h00, 32'd1);
    offer_body_item(OP_DATA, 8'hFF);
    send_header(8'h00, 32'd2);
    offer_body_item(OP_DATA, 8'h00);
    offer_body_item(OP_DATA, 8'hA5);
    set_size_limit(32'd1);
    send_header(8'h00, 32'd1);
    offer_body_item(OP_DATA, 8'h00);
    set_size_limit(32'd0);
    send_header(8'h00, 32'd0);
    set_size_limit(32'hFFFF_FFFF);

    // random well-formed frames, several limit settings
    phase_no = 0;
    while (items_sent < RandItems) begin
      if (phase_no > 0) set_size_limit(pick_limit());
      quiet = (phase_no == 2);
      if (phase_no == 1) hold_off_req = 1'b1;
      phase_end = items_sent + 200;
      while (items_sent < phase_end && items_sent < RandItems) begin
        len = pick_length();
        send_header(8'h00, len);
        send_payload(len);
      end
      phase_no++;
    end
    quiet = 1'b0;

    // the stream can only be broken or ended once per reset
    set_size_limit($urandom_range(40, 1000));
    fin = finish_case_e'($urandom_range(0, 4));
    case (fin)
      FIN_TOO_LONG: begin
        len = $urandom;
        if (len <= cur_limit) len = cur_limit + 32'd1;
        send_header(8'h00, len);
      end
      FIN_COMPRESSED: begin
        send_header(8'($urandom_range(1, 255)), $urandom);
      end
      FIN_CUT_HEADER: begin
        offer_body_item(OP_DATA, 8'($urandom));
        send_payload($urandom_range(0, 3));
        offer_body_item(OP_END, 8'($urandom));
      end
      FIN_CUT_PAYLOAD: begin
        len = $urandom_range(2, 20);
        send_header(8'h00, len);
        send_payload($urandom_range(0, len - 1));
        offer_body_item(OP_END, 8'($urandom));
      end
      default: offer_body_item(OP_END, 8'($urandom));
    endcase
    for (int i = 0; i < 20; i++) offer_body_item(1'($urandom), 8'($urandom));
    in_valid_i <= 1'b0;

    for (int w = 0; w < 20000 && sb.owed_q.size() != 0; w++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.owed_q.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, sb.owed_q.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/lpmd_pkg.sv
design/lpmd_frame.sv
design/length_prefixed_message_deframer.sv
design/lpmd_checker.sv
verif/tb_top.sv
